// ===== rtl/tcrq_pkg.sv =====
// Package for the two-class ratio queue: sizes, codes and word layouts.
// No dependencies.
package tcrq_pkg;
	localparam int Capacity = 64;
	localparam int IdBits = 16;
	localparam int PtrBits = $clog2(Capacity) + 1;
	localparam int IdxBits = $clog2(Capacity);
	localparam logic [PtrBits-1:0] NilPtr = PtrBits'(Capacity);

	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_DEQ = 2'd1;
	localparam logic [1:0] KIND_REM = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [6:0] general_waiting;
		logic [6:0] priority_waiting;
		logic next_class;
		logic [15:0] next_id;
		logic next_valid;
		logic served_class;
		logic [15:0] served_id;
		logic [1:0] status;
	} result_t;

	// one memory port command
	typedef struct packed {
		logic we;
		logic [IdxBits-1:0] addr;
		logic wr_id;
		logic wr_next;
		logic wr_prev;
		logic [IdBits-1:0] id;
		logic [PtrBits-1:0] nxt;
		logic [PtrBits-1:0] prv;
	} mem_cmd_t;

	typedef struct packed {
		logic [IdBits-1:0] id;
		logic [PtrBits-1:0] nxt;
		logic [PtrBits-1:0] prv;
	} mem_rd_t;
endpackage

// ===== rtl/tcrq_store.sv =====
// Entry store: id, next and prev links, one synchronous port, registered read.
// Depends on tcrq_pkg.
module tcrq_store import tcrq_pkg::*; (
	input logic clk,
	input mem_cmd_t cmd,
	output mem_rd_t rd
);
	logic [IdBits-1:0] id_mem [Capacity];
	logic [PtrBits-1:0] next_mem [Capacity];
	logic [PtrBits-1:0] prev_mem [Capacity];

	always_ff @(posedge clk) begin
		if (cmd.we && cmd.wr_id) id_mem[cmd.addr] <= cmd.id;
		if (cmd.we && cmd.wr_next) next_mem[cmd.addr] <= cmd.nxt;
		if (cmd.we && cmd.wr_prev) prev_mem[cmd.addr] <= cmd.prv;
		rd.id <= id_mem[cmd.addr];
		rd.nxt <= next_mem[cmd.addr];
		rd.prv <= prev_mem[cmd.addr];
	end
endmodule

// ===== rtl/two_class_ratio_queue_unit.sv =====
// Top level of the two-class ratio queue: sequencer, list heads, credit logic.
// Depends on tcrq_pkg and tcrq_store.
//
//  channel   | dir | tdata fields (low bit first)
//  s_axis    | in  | kind[1:0], client_id[17:2], client_class[18], pad to 24
//  m_axis    | out | status, served_id, served_class, next_valid, next_id,
//            |     | next_class, priority_waiting, general_waiting, pad to 56
//  cfg       | in  | priority_burst[3:0] (cfg_data 8 bits)
//
// After reset an init sweep chains the free list, one entry a cycle; no word is
// accepted during it. Enqueue: S_RD, S_ENQ, S_LNK (only behind a tail). Dequeue:
// S_RD, S_DEQ, S_UNL1, S_UNL2, S_FREE. Remove: S_SRCH, S_SRCHW per entry walked,
// S_SRCH again to switch lists, then S_UNL1, S_UNL2, S_FREE unless not found.
// All kinds end in S_HEAD, S_HEADW, S_OUT; full, empty and unused go there.
// One word at a time; a result waiting in the output register lets the next
// word in, which then holds in the output state until the register drains.
module two_class_ratio_queue_unit import tcrq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [23:0] s_axis_tdata, // kind, client_id, client_class
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata, // status .. general_waiting
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [7:0] cfg_data // priority_burst
);
	localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2,
		S_ENQ = 4'd3, S_LNK = 4'd4, S_DEQ = 4'd5, S_UNL1 = 4'd6,
		S_UNL2 = 4'd7, S_FREE = 4'd8, S_HEAD = 4'd9, S_HEADW = 4'd10,
		S_SRCH = 4'd11, S_SRCHW = 4'd12, S_OUT = 4'd13;

	logic [3:0] state_q;
	logic [PtrBits-1:0] init_q;
	logic [PtrBits-1:0] head_q [2];
	logic [PtrBits-1:0] tail_q [2];
	logic [PtrBits-1:0] free_q;
	logic [6:0] pcnt_q, gcnt_q;
	logic [3:0] credits_q, deficit_q, burst_q;
	logic [1:0] kind_q;
	logic [IdBits-1:0] cid_q;
	logic cls_q;
	logic [PtrBits-1:0] e_q, p_q, n_q;
	logic [1:0] status_q;
	logic [IdBits-1:0] sid_q;
	logic scls_q, ncls_q;
	result_t res_q;
	logic out_v_q;
	mem_cmd_t cmd;
	mem_rd_t rd;

	tcrq_store u_store (.clk(clk), .cmd(cmd), .rd(rd));

	logic pick;
	assign pick = (credits_q != 4'd0) || (gcnt_q == 7'd0);

	logic out_go;
	assign out_go = (state_q == S_OUT) && (!out_v_q || m_axis_tready);

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {5'd0, res_q};

	// store port per state
	always_comb begin
		cmd = '0;
		case (state_q)
			S_INIT: begin
				cmd.we = 1'b1; cmd.wr_next = 1'b1; cmd.wr_prev = 1'b1;
				cmd.addr = init_q[IdxBits-1:0]; cmd.nxt = init_q + 1'b1;
				cmd.prv = NilPtr;
			end
			S_RD: begin
				// enqueue reads the free entry; dequeue the head
				cmd.addr = (kind_q == KIND_ENQ) ? free_q[IdxBits-1:0]
					: head_q[pick][IdxBits-1:0];
			end
			S_ENQ: begin
				cmd.we = 1'b1; cmd.wr_id = 1'b1; cmd.wr_next = 1'b1;
				cmd.wr_prev = 1'b1; cmd.addr = e_q[IdxBits-1:0];
				cmd.id = cid_q; cmd.nxt = NilPtr; cmd.prv = tail_q[cls_q];
			end
			S_LNK: begin
				cmd.we = 1'b1; cmd.wr_next = 1'b1;
				cmd.addr = p_q[IdxBits-1:0]; cmd.nxt = e_q;
			end
			S_SRCH: cmd.addr = e_q[IdxBits-1:0];
			S_UNL1: begin
				cmd.we = (p_q != NilPtr); cmd.wr_next = 1'b1;
				cmd.addr = p_q[IdxBits-1:0]; cmd.nxt = n_q;
			end
			S_UNL2: begin
				cmd.we = (n_q != NilPtr); cmd.wr_prev = 1'b1;
				cmd.addr = n_q[IdxBits-1:0]; cmd.prv = p_q;
			end
			S_FREE: begin
				cmd.we = 1'b1; cmd.wr_next = 1'b1; cmd.wr_prev = 1'b1;
				cmd.addr = e_q[IdxBits-1:0]; cmd.nxt = free_q; cmd.prv = NilPtr;
			end
			S_HEAD: cmd.addr = head_q[pick][IdxBits-1:0];
			// keep reading the next head so its id stays on rd while the result waits
			S_HEADW, S_OUT: cmd.addr = e_q[IdxBits-1:0];
			default: cmd = '0;
		endcase
	end

	logic [3:0] minv;
	assign minv = (pcnt_q < {3'd0, burst_q}) ? pcnt_q[3:0] : burst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT; init_q <= '0; free_q <= '0;
			head_q[0] <= NilPtr; head_q[1] <= NilPtr;
			tail_q[0] <= NilPtr; tail_q[1] <= NilPtr;
			pcnt_q <= '0; gcnt_q <= '0; credits_q <= '0;
			deficit_q <= 4'd2; burst_q <= 4'd2; out_v_q <= 1'b0;
		end else begin
			if (cfg_valid) burst_q <= cfg_data[3:0];
			if (out_go) out_v_q <= 1'b1;
			else if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == PtrBits'(Capacity - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					kind_q <= s_axis_tdata[1:0];
					cid_q <= s_axis_tdata[17:2];
					sid_q <= '0; scls_q <= 1'b0;
					case (s_axis_tdata[1:0])
						KIND_ENQ: begin
							cls_q <= s_axis_tdata[18];
							if (free_q == NilPtr) begin
								status_q <= ST_FULL; state_q <= S_HEAD;
							end else begin
								status_q <= ST_OK; state_q <= S_RD;
							end
						end
						KIND_DEQ: if (pcnt_q + gcnt_q == 7'd0) begin
							status_q <= ST_EMPTY; state_q <= S_HEAD;
						end else begin
							status_q <= ST_OK; state_q <= S_RD;
						end
						KIND_REM: begin
							status_q <= ST_OK;
							cls_q <= 1'b0; e_q <= head_q[0];
							state_q <= S_SRCH;
						end
						default: begin
							status_q <= ST_OK; state_q <= S_HEAD;
						end
					endcase
				end
				S_RD: begin
					if (kind_q == KIND_ENQ) begin
						e_q <= free_q; state_q <= S_ENQ;
					end else begin
						cls_q <= pick; e_q <= head_q[pick]; state_q <= S_DEQ;
					end
				end
				S_ENQ: begin
					free_q <= rd.nxt; p_q <= tail_q[cls_q];
					tail_q[cls_q] <= e_q;
					if (tail_q[cls_q] == NilPtr) begin
						head_q[cls_q] <= e_q; state_q <= S_HEAD;
					end else state_q <= S_LNK;
					if (cls_q) begin
						if (credits_q < burst_q && deficit_q != 4'd0) begin
							credits_q <= credits_q + 1'b1;
							deficit_q <= deficit_q - 1'b1;
						end
						pcnt_q <= pcnt_q + 1'b1;
					end else gcnt_q <= gcnt_q + 1'b1;
				end
				S_LNK: state_q <= S_HEAD;
				S_DEQ: begin
					sid_q <= rd.id; scls_q <= cls_q;
					p_q <= rd.prv; n_q <= rd.nxt; state_q <= S_UNL1;
					if (cls_q) begin
						if (credits_q != 4'd0) credits_q <= credits_q - 1'b1;
						pcnt_q <= pcnt_q - 1'b1;
					end else begin
						gcnt_q <= gcnt_q - 1'b1;
						credits_q <= minv; deficit_q <= burst_q - minv;
					end
				end
				S_SRCH: begin
					if (e_q == NilPtr) begin
						if (cls_q) begin
							status_q <= ST_NOTFOUND; state_q <= S_HEAD;
						end else begin
							cls_q <= 1'b1; e_q <= head_q[1];
						end
					end else state_q <= S_SRCHW;
				end
				S_SRCHW: begin
					if (rd.id == cid_q) begin
						sid_q <= rd.id; scls_q <= cls_q;
						p_q <= rd.prv; n_q <= rd.nxt; state_q <= S_UNL1;
						if (cls_q) begin
							pcnt_q <= pcnt_q - 1'b1;
							if (pcnt_q - 1'b1 < {3'd0, credits_q}) begin
								if (credits_q != 4'd0) credits_q <= credits_q - 1'b1;
								if (deficit_q < burst_q) deficit_q <= deficit_q + 1'b1;
							end
						end else gcnt_q <= gcnt_q - 1'b1;
					end else begin
						e_q <= rd.nxt; state_q <= S_SRCH;
					end
				end
				S_UNL1: begin
					if (p_q == NilPtr) head_q[cls_q] <= n_q;
					state_q <= S_UNL2;
				end
				S_UNL2: begin
					if (n_q == NilPtr) tail_q[cls_q] <= p_q;
					state_q <= S_FREE;
				end
				S_FREE: begin
					free_q <= e_q; state_q <= S_HEAD;
				end
				S_HEAD: begin
					ncls_q <= pick; e_q <= head_q[pick]; state_q <= S_HEADW;
				end
				S_HEADW: state_q <= S_OUT;
				S_OUT: if (out_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word; load it only when the output register is free
	logic nv;
	assign nv = (pcnt_q + gcnt_q != 7'd0) && (e_q != NilPtr);
	always_ff @(posedge clk) begin
		if (out_go) begin
			res_q.status <= status_q;
			res_q.served_id <= sid_q;
			res_q.served_class <= scls_q;
			res_q.next_valid <= nv;
			res_q.next_id <= nv ? rd.id : '0;
			res_q.next_class <= nv ? ncls_q : 1'b0;
			res_q.priority_waiting <= pcnt_q;
			res_q.general_waiting <= gcnt_q;
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pcnt_q} + {1'b0, gcnt_q}) <= 8'(Capacity))
		else $error("count over capacity");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && free_q == NilPtr) |->
		({1'b0, pcnt_q} + {1'b0, gcnt_q}) == 8'(Capacity))
		else $error("free list empty but store not full");
	a_nohold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_v_q && !m_axis_tready) |=> state_q == S_OUT)
		else $error("result overwritten");
endmodule

// ===== dv/tb_two_class_ratio_queue_unit.sv =====
// Self-checking testbench for two_class_ratio_queue_unit: directed table, fill and drain,
// then random traffic; every word checked against a two-class queue predictor or typed row.
// Depends on tcrq_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_two_class_ratio_queue_unit;
	import tcrq_pkg::*;

	typedef struct {
		logic [1:0] kind;
		logic [15:0] id;
		logic cls;
		bit typed;
		result_t res;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0; // kind, client_id, client_class
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata; // status .. general_waiting
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_data = '0; // priority_burst

	// predictor state: one FIFO of ids per class plus the credit counters
	logic [15:0] general_ids[$];
	logic [15:0] priority_ids[$];
	logic [3:0] credits, deficit, burst;
	logic [15:0] id_pool[8];

	result_t pending_results[$];
	op_row_t dir_rows[$];
	int mismatches = 0;
	bit long_hold_done = 1'b0;

	always #4 clk = ~clk;

	two_class_ratio_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// priority is served while credits remain or nothing general waits
	function automatic logic serve_priority();
		return (credits != 0) || (general_ids.size() == 0);
	endfunction

	// Advance the queue state by one operation and return the word it reports.
	function automatic result_t queue_predict(logic [1:0] kind, logic [15:0] id, logic cls);
		result_t r;
		logic c;
		int found;
		logic fc;
		r = '0;
		r.status = ST_OK;
		case (kind)
			KIND_ENQ: begin
				if (general_ids.size() + priority_ids.size() >= Capacity) begin
					r.status = ST_FULL;
				end else if (cls) begin
					priority_ids.push_back(id);
					if (credits < burst && deficit > 0) begin
						credits++;
						deficit--;
					end
				end else begin
					general_ids.push_back(id);
				end
			end
			KIND_DEQ: begin
				c = serve_priority();
				if (general_ids.size() + priority_ids.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (c && priority_ids.size() == 0) begin
					r.status = ST_EMPTY;
				end else if (c) begin
					r.served_id = priority_ids.pop_front();
					r.served_class = 1'b1;
					if (credits > 0) credits--;
				end else begin
					r.served_id = general_ids.pop_front();
					// reload credits after a general client
					credits = (priority_ids.size() < burst) ? 4'(priority_ids.size()) : burst;
					deficit = burst - credits;
				end
			end
			KIND_REM: begin
				found = -1;
				fc = 1'b0;
				foreach (general_ids[k]) if (found < 0 && general_ids[k] == id) found = k;
				if (found < 0) begin
					foreach (priority_ids[k])
						if (found < 0 && priority_ids[k] == id) found = k;
					fc = 1'b1;
				end
				if (found < 0) begin
					r.status = ST_NOTFOUND;
				end else if (fc) begin
					r.served_id = id;
					r.served_class = 1'b1;
					priority_ids.delete(found);
					if (priority_ids.size() < credits) begin
						if (credits > 0) credits--;
						if (deficit < burst) deficit++;
					end
				end else begin
					r.served_id = id;
					general_ids.delete(found);
				end
			end
			default: ;
		endcase
		if (general_ids.size() + priority_ids.size() > 0) begin
			c = serve_priority();
			if (c && priority_ids.size() > 0) begin
				r.next_valid = 1'b1;
				r.next_id = priority_ids[0];
				r.next_class = 1'b1;
			end else if (!c) begin
				r.next_valid = 1'b1;
				r.next_id = general_ids[0];
			end
		end
		r.priority_waiting = 7'(priority_ids.size());
		r.general_waiting = 7'(general_ids.size());
		return r;
	endfunction

	// Offer one word, hold it until accepted, then record what it should report.
	task automatic send_op(logic [1:0] kind, logic [15:0] id, logic cls,
			bit typed, result_t tres);
		result_t p;
		int g;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, cls, id, kind};
		do @(posedge clk); while (!s_axis_tready);
		p = queue_predict(kind, id, cls);
		pending_results.push_back(typed ? tres : p);
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Write the burst register once the unit has drained.
	task automatic write_burst(logic [3:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= {4'($urandom_range(0, 15)), v};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		burst = v;
	endtask

	task automatic add_row(logic [1:0] k, logic [15:0] id, logic c, bit typed, result_t r);
		op_row_t row;
		row.kind = k;
		row.id = id;
		row.cls = c;
		row.typed = typed;
		row.res = r;
		dir_rows.push_back(row);
	endtask

	// Random op: mostly enqueue or dequeue, removals mostly aimed at ids that wait.
	task automatic random_op(int enq_pct);
		int r;
		logic [15:0] id;
		r = $urandom_range(0, 99);
		id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
		if (r < 4) begin
			send_op(2'd3, 16'($urandom), 1'($urandom), 0, '0);
		end else if (r < 4 + enq_pct) begin
			send_op(KIND_ENQ, id, 1'($urandom), 0, '0);
		end else if (r < 4 + enq_pct + (96 - enq_pct) * 3 / 4) begin
			send_op(KIND_DEQ, 16'($urandom), 1'($urandom), 0, '0);
		end else begin
			if ($urandom_range(0, 9) < 7) begin
				if (general_ids.size() > 0 && $urandom_range(0, 1))
					id = general_ids[$urandom_range(0, general_ids.size() - 1)];
				else if (priority_ids.size() > 0)
					id = priority_ids[$urandom_range(0, priority_ids.size() - 1)];
			end
			send_op(KIND_REM, id, 1'($urandom), 0, '0);
		end
	endtask

	// Compare each result word with the oldest expectation.
	always @(posedge clk) begin
		result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.served_id !== want.served_id ||
						got.served_class !== want.served_class ||
						got.next_valid !== want.next_valid || got.next_id !== want.next_id ||
						got.next_class !== want.next_class ||
						got.priority_waiting !== want.priority_waiting ||
						got.general_waiting !== want.general_waiting) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected st=%0d sid=%h scl=%0d nv=%0d nid=%h ncl=%0d pw=%0d gw=%0d, got st=%0d sid=%h scl=%0d nv=%0d nid=%h ncl=%0d pw=%0d gw=%0d",
							want.status, want.served_id, want.served_class, want.next_valid,
							want.next_id, want.next_class, want.priority_waiting,
							want.general_waiting, got.status, got.served_id, got.served_class,
							got.next_valid, got.next_id, got.next_class, got.priority_waiting,
							got.general_waiting);
				end
			end
		end
	end

	// Receiver: random back-pressure plus one long hold-off to fill the unit.
	initial begin
		int n, g, cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
			m_axis_tready <= 1'b1;
			repeat (n) @(posedge clk);
			cyc += n;
			g = pick_gap();
			if (!long_hold_done && cyc > 600) begin
				g = 500;
				long_hold_done = 1'b1;
			end
			if (g > 0) begin
				m_axis_tready <= 1'b0;
				repeat (g) @(posedge clk);
				cyc += g;
			end
		end
	end

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		result_t t;
		logic [3:0] bursts[10];
		credits = 4'd0;
		deficit = 4'd2;
		burst = 4'd2;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-store cases typed, the rest predicted
		t = '0;
		t.status = ST_EMPTY;
		add_row(KIND_DEQ, 16'h0000, 1'b0, 1, t);
		t.status = ST_NOTFOUND;
		add_row(KIND_REM, 16'h0000, 1'b1, 1, t);
		t.status = ST_OK;
		add_row(2'd3, 16'hffff, 1'b1, 1, t);
		t.next_valid = 1'b1;
		t.next_id = 16'hffff;
		t.general_waiting = 7'd1;
		add_row(KIND_ENQ, 16'hffff, 1'b0, 1, t);
		add_row(KIND_ENQ, 16'h0000, 1'b1, 0, '0);
		add_row(KIND_ENQ, 16'h1234, 1'b1, 0, '0);
		add_row(KIND_ENQ, 16'h0000, 1'b0, 0, '0);
		add_row(KIND_ENQ, 16'hffff, 1'b1, 0, '0);
		add_row(KIND_ENQ, 16'h5a5a, 1'b1, 0, '0);
		add_row(KIND_DEQ, 16'h0000, 1'b0, 0, '0);
		add_row(KIND_DEQ, 16'h0000, 1'b0, 0, '0);
		add_row(KIND_REM, 16'hffff, 1'b0, 0, '0);
		add_row(KIND_REM, 16'h5a5a, 1'b0, 0, '0);
		add_row(KIND_REM, 16'hbeef, 1'b0, 0, '0);
		add_row(KIND_DEQ, 16'h0000, 1'b0, 0, '0);
		add_row(KIND_DEQ, 16'h0000, 1'b0, 0, '0);
		add_row(KIND_DEQ, 16'h0000, 1'b0, 0, '0);
		add_row(KIND_DEQ, 16'h0000, 1'b0, 0, '0);
		foreach (dir_rows[k])
			send_op(dir_rows[k].kind, dir_rows[k].id, dir_rows[k].cls,
				dir_rows[k].typed, dir_rows[k].res);

		// fill to capacity, overflow once, then drain past empty
		for (int k = 0; k <= Capacity; k++)
			send_op(KIND_ENQ, 16'($urandom), 1'($urandom), 0, '0);
		for (int k = 0; k <= Capacity; k++)
			send_op(KIND_DEQ, 16'h0000, 1'b0, 0, '0);

		// random phases, each under its own burst setting
		bursts = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd15, 4'd0, 4'd3, 4'd1, 4'd8, 4'd15};
		for (int ph = 0; ph < 10; ph++) begin
			int enq_pct;
			if (ph > 2) bursts[ph] = ($urandom_range(0, 2) == 0) ? bursts[ph]
				: 4'($urandom_range(1, 15));
			write_burst(bursts[ph]);
			foreach (id_pool[k]) id_pool[k] = 16'($urandom);
			id_pool[0] = 16'h0000;
			id_pool[1] = 16'hffff;
			enq_pct = (ph % 3 == 0) ? 70 : ((ph % 3 == 1) ? 50 : 30);
			repeat (55) random_op(enq_pct);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ===== files.f =====
rtl/tcrq_pkg.sv
rtl/tcrq_store.sv
rtl/two_class_ratio_queue_unit.sv
dv/tb_two_class_ratio_queue_unit.sv
